FILE: sv/spcp_pkg.sv
// Shared types and constants for the shelf-pack centered placer.
package spcp_pkg;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned STACK_W    = 17;
  localparam int unsigned IN_DATA_W  = 2 * FIELD_W;
  localparam int unsigned OUT_DATA_W = 2 * FIELD_W;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [FIELD_W-1:0] DECK_RESET = 16'd64;
  localparam logic [STACK_W-1:0] STACK_MAX  = 17'h1FFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECK_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECK_HEIGHT = 1'b1;

  // Phases of one set: load cells, close the last row, walk placements
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_FINAL = 3'b010,
    ST_WALK  = 3'b100
  } state_e;

endpackage

FILE: sv/spcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spcp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/shelf_pack_centered_placer.sv
// Shelf-pack centered placer: packs blocks next-fit into rows, then emits centered placements.
// Flow: cells are taken one per cycle while in the load phase; the first placement follows the
//   set_end cell through row close, block RAM read, row RAM read and output register.
// Throughput: then one placement per cycle while m_axis_tready is high, set by the two-RAM read
//   pipeline; a new set is taken the cycle after the final placement leaves.
// Reset: packing state clears to zero and both deck registers to 64; RAM contents are not
//   cleared, every entry read in a walk is written earlier in the same set.
module shelf_pack_centered_placer #(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // cfg port
  input  logic                               cfg_we_i,
  input  logic [spcp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [spcp_pkg::FIELD_W-1:0]       cfg_data_i,
  // cell requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [spcp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // cell_dx, cell_dy
  input  logic                               s_axis_tlast,  // block_end
  input  logic                               s_axis_tuser,  // set_end
  // placement requests
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [spcp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // place_x, place_y
  output logic                               m_axis_tlast   // final_flag
);

  import spcp_pkg::*;

  localparam int unsigned ROW_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned ROWS   = MAX_BLOCKS + 1;
  localparam logic [FIELD_W-1:0] COORD_MAX = FIELD_W'((COORD_BITS >= FIELD_W) ?
      ((64'd1 << FIELD_W) - 64'd1) : ((64'd1 << COORD_BITS) - 64'd1));

  typedef struct packed {
    logic [STACK_W-1:0] pref;
    logic [FIELD_W-1:0] off;
    logic [ROW_W-1:0]   row;
  } blk_t;

  localparam int unsigned BLK_W = $bits(blk_t);

  state_e state_q;

  logic [FIELD_W-1:0] deck_w_q, deck_h_q;
  logic [FIELD_W-1:0] cursor_q, height_q, max_dx_q, max_dy_q;
  logic [ROW_W-1:0]   row_q;
  logic [CNT_W-1:0]   count_q, n_q, rd_cnt_q;
  logic [STACK_W-1:0] stack_q;
  logic [FIELD_W-1:0] top_q;

  logic               s1_valid_q, s1_last_q, s2_valid_q, s2_last_q;
  logic               out_valid_q, out_last_q;
  logic [FIELD_W-1:0] s2_off_q, out_x_q, out_y_q;
  logic [STACK_W-1:0] s2_pref_q;

  // Load-side signals
  logic               in_acc, fin, full, store, close;
  logic [FIELD_W-1:0] cell_dx, cell_dy, dx_new, dy_new, bh_sat, hgt_base, hgt_new;
  logic [FIELD_W:0]   bw, bh, cur_sum, cur_base;
  logic [STACK_W:0]   stack_add;
  logic [STACK_W-1:0] stack_sat;
  blk_t               blk_wr, blk_rd;

  // Final-phase signals
  logic [STACK_W:0]   total_add;
  logic [STACK_W-1:0] total_sat;
  logic [STACK_W-1:0] deck_h_ext, top_diff;

  // Walk-side signals
  logic               en, issue, walk_done;
  logic [BLK_W-1:0]   blk_rdata;
  logic [FIELD_W-1:0] rw_rdata, center;
  logic [FIELD_W:0]   x_sum;
  logic [STACK_W:0]   y_sum;

  logic               row_we;

  assign cell_dx = s_axis_tdata[FIELD_W-1:0];
  assign cell_dy = s_axis_tdata[IN_DATA_W-1:FIELD_W];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fin           = in_acc && (s_axis_tlast || s_axis_tuser);
  assign full          = (count_q == CNT_W'(MAX_BLOCKS));
  assign store         = fin && !full;

  // Bounding box including the current cell
  assign dx_new = (cell_dx > max_dx_q) ? cell_dx : max_dx_q;
  assign dy_new = (cell_dy > max_dy_q) ? cell_dy : max_dy_q;
  assign bw     = {1'b0, dx_new} + (FIELD_W+1)'(1);
  assign bh     = {1'b0, dy_new} + (FIELD_W+1)'(1);
  assign bh_sat = bh[FIELD_W] ? {FIELD_W{1'b1}} : bh[FIELD_W-1:0];

  // Next-fit decision: open a new row when the block overruns the deck, unless on the last row
  assign cur_sum  = {1'b0, cursor_q} + bw;
  assign close    = (cur_sum > {1'b0, deck_w_q}) && (row_q != ROW_W'(MAX_BLOCKS));
  assign cur_base = close ? bw : cur_sum;
  assign hgt_base = close ? '0 : height_q;
  assign hgt_new  = (bh_sat > hgt_base) ? bh_sat : hgt_base;

  // Stack height after closing the current row, saturated
  assign stack_add = {1'b0, stack_q} + (STACK_W+1)'(height_q);
  assign stack_sat = stack_add[STACK_W] ? STACK_MAX : stack_add[STACK_W-1:0];

  assign blk_wr.row  = close ? ROW_W'(row_q + 1'b1) : row_q;
  assign blk_wr.off  = close ? '0 : cursor_q;
  assign blk_wr.pref = close ? stack_sat : stack_q;

  // Vertical centering of the whole stack
  assign total_add  = {1'b0, stack_q} + (STACK_W+1)'(height_q);
  assign total_sat  = total_add[STACK_W] ? STACK_MAX : total_add[STACK_W-1:0];
  assign deck_h_ext = STACK_W'(deck_h_q);
  assign top_diff   = deck_h_ext - total_sat;

  // Row widths are written on a row close and for the last row of the set
  assign row_we = (store && close) || (state_q == ST_FINAL);

  // Walk pipeline advances unless the output register is stalled
  assign en        = !(out_valid_q && !m_axis_tready);
  assign issue     = (state_q == ST_WALK) && (rd_cnt_q != n_q);
  assign walk_done = out_valid_q && m_axis_tready && out_last_q;
  assign blk_rd    = blk_t'(blk_rdata);

  spcp_ram #(
    .WIDTH (BLK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (blk_wr),
    .re_i    (en && issue),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (blk_rdata)
  );

  spcp_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_q),
    .wdata_i (cursor_q),
    .re_i    (en && s1_valid_q),
    .raddr_i (blk_rd.row),
    .rdata_o (rw_rdata)
  );

  // Horizontal centering of the row, then saturate both coordinates
  assign center = (deck_w_q > rw_rdata) ? FIELD_W'((deck_w_q - rw_rdata) >> 1) : '0;
  assign x_sum  = {1'b0, center} + {1'b0, s2_off_q};
  assign y_sum  = (STACK_W+1)'(top_q) + {1'b0, s2_pref_q};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_w_q <= DECK_RESET;
      deck_h_q <= DECK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DECK_WIDTH:  deck_w_q <= cfg_data_i;
        CFG_DECK_HEIGHT: deck_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Packing state and phase control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cursor_q <= '0;
      height_q <= '0;
      max_dx_q <= '0;
      max_dy_q <= '0;
      row_q    <= '0;
      count_q  <= '0;
      stack_q  <= '0;
      n_q      <= '0;
      rd_cnt_q <= '0;
      top_q    <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (fin) begin
              max_dx_q <= '0;
              max_dy_q <= '0;
            end else begin
              max_dx_q <= dx_new;
              max_dy_q <= dy_new;
            end
          end
          if (store) begin
            cursor_q <= cur_base[FIELD_W] ? {FIELD_W{1'b1}} : cur_base[FIELD_W-1:0];
            height_q <= hgt_new;
            count_q  <= CNT_W'(count_q + 1'b1);
            if (close) begin
              row_q   <= ROW_W'(row_q + 1'b1);
              stack_q <= stack_sat;
            end
          end
          if (in_acc && s_axis_tuser) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          top_q    <= (deck_h_ext > total_sat) ? FIELD_W'(top_diff >> 1) : '0;
          n_q      <= count_q;
          rd_cnt_q <= '0;
          cursor_q <= '0;
          height_q <= '0;
          row_q    <= '0;
          count_q  <= '0;
          stack_q  <= '0;
          state_q  <= ST_WALK;
        end
        ST_WALK: begin
          if (en && issue) begin
            rd_cnt_q <= CNT_W'(rd_cnt_q + 1'b1);
          end
          if (walk_done) begin
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // Walk pipeline valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= issue;
      s1_last_q   <= (rd_cnt_q == CNT_W'(n_q - 1'b1));
      s2_valid_q  <= s1_valid_q;
      s2_last_q   <= s1_last_q;
      out_valid_q <= s2_valid_q;
      out_last_q  <= s2_last_q;
    end
  end

  // Walk pipeline payload
  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      s2_off_q  <= blk_rd.off;
      s2_pref_q <= blk_rd.pref;
    end
    if (en && s2_valid_q) begin
      out_x_q <= (x_sum > (FIELD_W+1)'(COORD_MAX)) ? COORD_MAX : x_sum[FIELD_W-1:0];
      out_y_q <= (y_sum > (STACK_W+1)'(COORD_MAX)) ? COORD_MAX : y_sum[FIELD_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond capacity");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_W'(MAX_BLOCKS))
    else $error("row index beyond row store");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (n_q != '0) && (rd_cnt_q <= n_q))
    else $error("walk over an empty or overrun block list");

  a_last_all_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (rd_cnt_q == n_q) && !s1_valid_q && !s2_valid_q)
    else $error("final placement shown before the walk drained");

  a_final_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |=> (state_q == ST_WALK))
    else $error("row close phase did not hand over to the walk");
`endif

endmodule
